// File: hw/rtl/wstt_pkg.sv
// ----------------------------------------------------------------------------
// wstt_pkg
// Shared types and constants for the station tracking table.
// ----------------------------------------------------------------------------
package wstt_pkg;

  localparam int AP_SLOTS     = 64;
  localparam int CLIENT_SLOTS = 32;
  localparam int AP_W         = 6;
  localparam int CL_W         = 5;
  localparam int ROW_W        = AP_W + 1;            // AP rows plus orphan row
  localparam int MEM_DEPTH    = (AP_SLOTS + 1) * CLIENT_SLOTS;
  localparam int MEM_AW       = 12;

  localparam logic [ROW_W-1:0]  ORPHAN_ROW = ROW_W'(AP_SLOTS);
  localparam logic [MEM_AW-1:0] CLEAR_LAST = MEM_AW'(MEM_DEPTH - 1);
  localparam logic [47:0]       MAC_BCAST  = 48'hFFFF_FFFF_FFFF;
  localparam logic [23:0]       MC_IPV6    = 24'h333300;
  localparam logic [23:0]       MC_IPV4    = 24'h01005E;

  // opcodes
  localparam logic [2:0] OP_AP_REPORT = 3'd0;
  localparam logic [2:0] OP_FRAME     = 3'd1;
  localparam logic [2:0] OP_AGE       = 3'd2;
  localparam logic [2:0] OP_RD_AP     = 3'd3;
  localparam logic [2:0] OP_RD_CLIENT = 3'd4;
  localparam logic [2:0] OP_RD_ORPHAN = 3'd5;

  // result status
  localparam logic [2:0] RS_UPDATED = 3'd0;
  localparam logic [2:0] RS_ADDED   = 3'd1;
  localparam logic [2:0] RS_FULL    = 3'd2;
  localparam logic [2:0] RS_DROPPED = 3'd3;
  localparam logic [2:0] RS_READ    = 3'd4;
  localparam logic [2:0] RS_TICK    = 3'd5;

  // target table
  localparam logic [1:0] TT_AP     = 2'd0;
  localparam logic [1:0] TT_CLIENT = 2'd1;
  localparam logic [1:0] TT_ORPHAN = 2'd2;

  typedef struct packed {
    logic [47:0] addr;
    logic [7:0]  sig;
    logic [3:0]  ch;
    logic [2:0]  sec;
    logic [3:0]  life;
  } ap_ent_t;

  typedef struct packed {
    logic [47:0] addr;
    logic [47:0] peer;
    logic [7:0]  sig;
    logic [2:0]  life;
  } cl_ent_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    cl_ent_t           data;
  } cl_wr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  target;
    logic [5:0]  ap_slot;
    logic [4:0]  entry_slot;
    logic        valid;
    logic [47:0] addr;
    logic [47:0] peer;
    logic [7:0]  sig;
    logic [3:0]  ch;
    logic [2:0]  sec;
    logic [3:0]  life;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AP_SCAN,
    ST_CL_SCAN,
    ST_ROW_CLR,
    ST_AGE_SEL,
    ST_AGE_ROW,
    ST_RD,
    ST_RD_OUT,
    ST_DONE
  } state_t;

endpackage

// File: hw/rtl/wireless_station_tracking_table_top.sv
// ----------------------------------------------------------------------------
// wireless_station_tracking_table_top
// Access point / client / orphan MAC table with lifetimes, one word at a time.
// Per word: a read fetches one entry; an AP report scans the 64 AP entries
//   and clears the client row on add; a frame scans them, then a 32-entry
//   client row; an age tick ages each live AP row, then the orphan row. One
//   word in flight; single read port per table, scanned one entry per cycle.
// Reset: clearing pass over the tables, ready low meanwhile.
// ----------------------------------------------------------------------------
module wireless_station_tracking_table_top import wstt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic [47:0]        address_one,
  input  logic [47:0]        address_two,
  input  logic signed [7:0]  signal_level,
  input  logic [3:0]         radio_channel,
  input  logic [2:0]         security_mode,
  input  logic               toward_ds,
  input  logic               away_from_ds,
  input  logic               record_usable,
  input  logic [5:0]         ap_slot_index,
  input  logic [4:0]         entry_slot_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [1:0]         target_table,
  output logic [5:0]         ap_slot,
  output logic [4:0]         entry_slot,
  output logic               entry_valid,
  output logic [47:0]        entry_address,
  output logic [47:0]        entry_peer_address,
  output logic signed [7:0]  entry_signal,
  output logic [3:0]         entry_channel,
  output logic [2:0]         entry_security,
  output logic signed [3:0]  entry_lifetime
);

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  state_t            state, state_next;
  logic [MEM_AW-1:0] clr_cnt;
  logic [2:0]        life_cfg;
  logic [2:0]        life_ld;       // zero register value loads as one

  // latched word
  logic [2:0]  op;
  logic [47:0] key_ap;              // bssid on report, server on frame
  logic [47:0] key_cl;              // client MAC on frame
  logic [7:0]  sig;
  logic [3:0]  ch;
  logic [2:0]  sec;
  logic [5:0]  asi;
  logic [4:0]  esi;

  // scan sequencer: cnt issues reads, chk_* tracks the data in the following cycle
  logic [6:0]       cnt;
  logic             chk_vld;
  logic [5:0]       chk_idx;
  logic             free_vld;
  logic [5:0]       free_idx;
  logic [ROW_W-1:0] row;
  logic             cnt_run;

  logic [AP_SLOTS-1:0] in_use;

  // AP store
  ap_ent_t    ap_mem [AP_SLOTS];
  ap_ent_t    ap_q;
  logic       ap_we;
  logic [5:0] ap_waddr;
  ap_ent_t    ap_wdata;
  logic [5:0] ap_raddr;

  // client store
  cl_wr_t            cl_wr;
  logic [MEM_AW-1:0] cl_raddr;
  cl_ent_t           cl_q;

  res_t res, res_next, out_r;
  logic res_ld;

  // --------------------------------------------------------------------------
  // Frame classification at the input
  // --------------------------------------------------------------------------
  logic [47:0] in_server, in_client;
  logic        in_drop;

  assign in_server = toward_ds ? address_one : address_two;
  assign in_client = toward_ds ? address_two : address_one;
  assign in_drop   = !record_usable || (toward_ds == away_from_ds) ||
                     (in_client == MAC_BCAST) || (in_client[47:24] == MC_IPV6) ||
                     (in_client[47:24] == MC_IPV4);

  assign in_ready = (state == ST_IDLE);
  assign life_ld  = (life_cfg == 3'd0) ? 3'd1 : life_cfg;

  // --------------------------------------------------------------------------
  // Scan compare unit (one entry per cycle)
  // --------------------------------------------------------------------------
  logic       ap_hit, ap_free_now, ap_last, fr_any_ap;
  logic [5:0] fr_ap;
  logic       cl_live, cl_hit, cl_free_now, cl_last, fr_any_cl;
  logic [4:0] fr_cl;
  logic       is_orphan;

  assign ap_hit      = chk_vld && in_use[chk_idx] && (ap_q.addr == key_ap);
  assign ap_free_now = chk_vld && !in_use[chk_idx];
  assign ap_last     = chk_vld && (chk_idx == 6'(AP_SLOTS - 1));
  assign fr_any_ap   = free_vld || ap_free_now;
  assign fr_ap       = free_vld ? free_idx : chk_idx;

  assign cl_live     = (cl_q.life != 3'd0);
  assign cl_hit      = chk_vld && cl_live && (cl_q.addr == key_cl);
  assign cl_free_now = chk_vld && !cl_live;
  assign cl_last     = chk_vld && (chk_idx == 6'(CLIENT_SLOTS - 1));
  assign fr_any_cl   = free_vld || cl_free_now;
  assign fr_cl       = free_vld ? free_idx[4:0] : chk_idx[4:0];
  assign is_orphan   = (row == ORPHAN_ROW);

  assign cnt_run = ((state == ST_AP_SCAN) && !cnt[6]) ||
                   (((state == ST_CL_SCAN) || (state == ST_AGE_ROW) ||
                     (state == ST_ROW_CLR)) && !cnt[5]);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLEAR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (opcode) inside
            OP_AP_REPORT: state_next = ST_AP_SCAN;
            OP_FRAME:     state_next = in_drop ? ST_DONE : ST_AP_SCAN;
            OP_AGE:       state_next = ST_AGE_SEL;
            OP_RD_AP, OP_RD_CLIENT, OP_RD_ORPHAN: state_next = ST_RD;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_AP_SCAN: begin
        if (ap_hit) begin
          state_next = (op == OP_AP_REPORT) ? ST_DONE : ST_CL_SCAN;
        end else if (ap_last) begin
          if (op == OP_AP_REPORT) state_next = fr_any_ap ? ST_ROW_CLR : ST_DONE;
          else                    state_next = ST_CL_SCAN;
        end
      end
      ST_CL_SCAN: begin
        if (cl_hit || cl_last) state_next = ST_DONE;
      end
      ST_ROW_CLR: begin
        if (cnt[4:0] == 5'(CLIENT_SLOTS - 1)) state_next = ST_DONE;
      end
      ST_AGE_SEL: begin
        if (is_orphan || in_use[row[5:0]]) state_next = ST_AGE_ROW;
      end
      ST_AGE_ROW: begin
        if (cl_last) state_next = is_orphan ? ST_DONE : ST_AGE_SEL;
      end
      ST_RD:     state_next = ST_RD_OUT;
      ST_RD_OUT: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Memory controls and result
  // --------------------------------------------------------------------------
  always_comb begin
    logic [3:0] ap_life_n;
    logic [2:0] cl_life_n;
    ap_life_n = ap_q.life - 4'd1;
    cl_life_n = cl_q.life - 3'd1;
    ap_we     = 1'b0;
    ap_waddr  = chk_idx;
    ap_wdata  = ap_q;
    cl_wr     = '0;
    res_ld    = 1'b0;
    res_next  = '0;
    ap_raddr  = cnt[5:0];
    cl_raddr  = {row, cnt[4:0]};

    unique case (state)
      ST_CLEAR: begin
        ap_we    = (clr_cnt[MEM_AW-1:AP_W] == '0);
        ap_waddr = clr_cnt[AP_W-1:0];
        ap_wdata = '0;
        cl_wr.we   = 1'b1;
        cl_wr.addr = clr_cnt;
      end
      ST_IDLE: begin
        res_ld          = in_valid;
        res_next.status = RS_DROPPED;
      end
      ST_AP_SCAN: begin
        if (op == OP_AP_REPORT) begin
          if (ap_hit) begin
            ap_we          = 1'b1;
            ap_wdata.sig   = sig;
            ap_wdata.ch    = ch;
            ap_wdata.life  = {1'b0, life_ld};
            res_ld         = 1'b1;
            res_next.status  = RS_UPDATED;
            res_next.target  = TT_AP;
            res_next.ap_slot = chk_idx;
            res_next.valid   = 1'b1;
            res_next.addr    = ap_q.addr;
            res_next.sig     = sig;
            res_next.ch      = ch;
            res_next.sec     = ap_q.sec;
            res_next.life    = {1'b0, life_ld};
          end else if (ap_last) begin
            res_ld = 1'b1;
            if (fr_any_ap) begin
              ap_we         = 1'b1;
              ap_waddr      = fr_ap;
              ap_wdata.addr = key_ap;
              ap_wdata.sig  = sig;
              ap_wdata.ch   = ch;
              ap_wdata.sec  = sec;
              ap_wdata.life = {1'b0, life_ld};
              res_next.status  = RS_ADDED;
              res_next.target  = TT_AP;
              res_next.ap_slot = fr_ap;
              res_next.valid   = 1'b1;
              res_next.addr    = key_ap;
              res_next.sig     = sig;
              res_next.ch      = ch;
              res_next.sec     = sec;
              res_next.life    = {1'b0, life_ld};
            end else begin
              res_next.status = RS_FULL;
              res_next.target = TT_AP;
            end
          end
        end
      end
      ST_CL_SCAN: begin
        res_next.target  = is_orphan ? TT_ORPHAN : TT_CLIENT;
        res_next.ap_slot = is_orphan ? 6'd0 : row[5:0];
        if (cl_hit) begin
          cl_wr.we        = 1'b1;
          cl_wr.addr      = {row, chk_idx[4:0]};
          cl_wr.data      = cl_q;
          cl_wr.data.sig  = sig;
          cl_wr.data.life = life_ld;
          res_ld              = 1'b1;
          res_next.status     = RS_UPDATED;
          res_next.entry_slot = chk_idx[4:0];
          res_next.valid      = 1'b1;
          res_next.addr       = cl_q.addr;
          res_next.peer       = is_orphan ? cl_q.peer : 48'd0;
          res_next.sig        = sig;
          res_next.life       = {1'b0, life_ld};
        end else if (cl_last) begin
          res_ld = 1'b1;
          if (fr_any_cl) begin
            cl_wr.we        = 1'b1;
            cl_wr.addr      = {row, fr_cl};
            cl_wr.data.addr = key_cl;
            cl_wr.data.peer = is_orphan ? key_ap : 48'd0;
            cl_wr.data.sig  = sig;
            cl_wr.data.life = life_ld;
            res_next.status     = RS_ADDED;
            res_next.entry_slot = fr_cl;
            res_next.valid      = 1'b1;
            res_next.addr       = key_cl;
            res_next.peer       = is_orphan ? key_ap : 48'd0;
            res_next.sig        = sig;
            res_next.life       = {1'b0, life_ld};
          end else begin
            res_next.status = RS_FULL;
          end
        end
      end
      ST_ROW_CLR: begin
        cl_wr.we   = 1'b1;
        cl_wr.addr = {row, cnt[4:0]};
      end
      ST_AGE_SEL: begin
        ap_raddr = row[5:0];
      end
      ST_AGE_ROW: begin
        ap_raddr = row[5:0];
        // AP entry counts down once, on the first data cycle of its row
        if (chk_vld && (chk_idx == 6'd0) && !is_orphan) begin
          ap_we         = 1'b1;
          ap_waddr      = row[5:0];
          ap_wdata.life = ap_life_n;
          if (ap_life_n[3]) ap_wdata.sig = 8'd0;
        end
        if (chk_vld && cl_live) begin
          cl_wr.we        = 1'b1;
          cl_wr.addr      = {row, chk_idx[4:0]};
          cl_wr.data      = cl_q;
          cl_wr.data.life = cl_life_n;
          if (cl_life_n == 3'd0) cl_wr.data = '0;
        end
        if (cl_last && is_orphan) begin
          res_ld          = 1'b1;
          res_next.status = RS_TICK;
        end
      end
      ST_RD: begin
        ap_raddr = asi;
        cl_raddr = (op == OP_RD_CLIENT) ? {1'b0, asi, esi} : {ORPHAN_ROW, esi};
      end
      ST_RD_OUT: begin
        res_ld          = 1'b1;
        res_next.status = RS_READ;
        if (op == OP_RD_AP) begin
          res_next.target  = TT_AP;
          res_next.ap_slot = asi;
          res_next.valid   = in_use[asi];
          res_next.addr    = ap_q.addr;
          res_next.sig     = ap_q.sig;
          res_next.ch      = ap_q.ch;
          res_next.sec     = ap_q.sec;
          res_next.life    = ap_q.life;
        end else begin
          res_next.target     = (op == OP_RD_CLIENT) ? TT_CLIENT : TT_ORPHAN;
          res_next.ap_slot    = (op == OP_RD_CLIENT) ? asi : 6'd0;
          res_next.entry_slot = esi;
          res_next.valid      = cl_live;
          res_next.addr       = cl_q.addr;
          res_next.peer       = (op == OP_RD_CLIENT) ? 48'd0 : cl_q.peer;
          res_next.sig        = cl_q.sig;
          res_next.life       = {1'b0, cl_q.life};
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      life_cfg  <= 3'd3;
      in_use    <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      chk_vld   <= 1'b0;
      free_vld  <= 1'b0;
      row       <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) life_cfg <= cfg_data;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;

      // scan sequencer
      chk_vld <= cnt_run && (state != ST_ROW_CLR);
      if (cnt_run) cnt <= cnt + 1'b1;
      if ((state_next != state) &&
          ((state_next == ST_AP_SCAN) || (state_next == ST_CL_SCAN) ||
           (state_next == ST_ROW_CLR) || (state_next == ST_AGE_ROW))) begin
        cnt      <= '0;
        chk_vld  <= 1'b0;
        free_vld <= 1'b0;
      end else if (!free_vld &&
                   (((state == ST_AP_SCAN) && ap_free_now) ||
                    ((state == ST_CL_SCAN) && cl_free_now))) begin
        free_vld <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) row <= '0;
        end
        ST_AP_SCAN: begin
          if (ap_hit) begin
            row <= {1'b0, chk_idx};
          end else if (ap_last) begin
            if (op == OP_AP_REPORT) begin
              row <= {1'b0, fr_ap};
              if (fr_any_ap) in_use[fr_ap] <= 1'b1;
            end else begin
              row <= ORPHAN_ROW;
            end
          end
        end
        ST_AGE_SEL: begin
          if (!is_orphan && !in_use[row[5:0]]) row <= row + 1'b1;
        end
        ST_AGE_ROW: begin
          if (chk_vld && (chk_idx == 6'd0) && !is_orphan && ap_wdata.life[3]) begin
            in_use[row[5:0]] <= 1'b0;
          end
          if (cl_last && !is_orphan) row <= row + 1'b1;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
      if ((state != ST_DONE) && out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_idx <= cnt[5:0];
    if (chk_vld && ((state == ST_AP_SCAN) || (state == ST_CL_SCAN)) && !free_vld) begin
      free_idx <= chk_idx;
    end
    if (in_ready && in_valid) begin
      op     <= opcode;
      key_ap <= (opcode == OP_FRAME) ? in_server : address_one;
      key_cl <= in_client;
      sig    <= signal_level;
      ch     <= radio_channel;
      sec    <= security_mode;
      asi    <= ap_slot_index;
      esi    <= entry_slot_index;
    end
    if (res_ld) res <= res_next;
    if ((state == ST_DONE) && (!out_valid || out_ready)) out_r <= res;
  end

  // AP store: one write, one registered read
  always_ff @(posedge clk) begin
    if (ap_we) ap_mem[ap_waddr] <= ap_wdata;
    ap_q <= ap_mem[ap_raddr];
  end

  wstt_cl_mem u_cl_mem (
    .clk   (clk),
    .wr    (cl_wr),
    .raddr (cl_raddr),
    .rdata (cl_q)
  );

  // --------------------------------------------------------------------------
  // Output word
  // --------------------------------------------------------------------------
  assign status             = out_r.status;
  assign target_table       = out_r.target;
  assign ap_slot            = out_r.ap_slot;
  assign entry_slot         = out_r.entry_slot;
  assign entry_valid        = out_r.valid;
  assign entry_address      = out_r.addr;
  assign entry_peer_address = out_r.peer;
  assign entry_signal       = out_r.sig;
  assign entry_channel      = out_r.ch;
  assign entry_security     = out_r.sec;
  assign entry_lifetime     = out_r.life;

endmodule

// File: hw/rtl/wstt_cl_mem.sv
// ----------------------------------------------------------------------------
// wstt_cl_mem
// Client and orphan entry store: one row per access point plus an orphan row.
// ----------------------------------------------------------------------------
module wstt_cl_mem import wstt_pkg::*; (
  input  logic              clk,
  input  cl_wr_t            wr,
  input  logic [MEM_AW-1:0] raddr,
  output cl_ent_t           rdata
);

  cl_ent_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
